[src/id3u8_pkg.sv]
// Package with shared types and constants for the ID3 text to UTF-8 converter.
`timescale 1ns / 1ps

package id3u8_pkg;

  localparam int CAP_W = 13;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;
  localparam int JOBQ_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_LATIN1 = 2'd0,
    MODE_UTF8   = 2'd1,
    MODE_UTF16  = 2'd2
  } mode_t;

  localparam logic [7:0] ENC_LATIN1 = 8'd0;
  localparam logic [7:0] ENC_UTF16_BOM = 8'd1;
  localparam logic [7:0] ENC_UTF16_BE = 8'd2;
  localparam logic [7:0] ENC_UTF8 = 8'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // One accepted input byte turns into up to three data bytes and a terminator.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            term;
  } job_t;

endpackage

[src/id3u8_front.sv]
// Front end: decodes the encoding and code units and builds output jobs.
`timescale 1ns / 1ps

module id3u8_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [id3u8_pkg::CAP_W-1:0] cfg_data,
  input  logic                       accept,
  input  id3u8_pkg::in_word_t        in_data,
  output logic                       job_push,
  output id3u8_pkg::job_t            job
);
  import id3u8_pkg::*;

  logic [CAP_W-1:0] out_capacity;
  logic             at_start, at_start_next;
  mode_t            mode, mode_next;
  logic             big_endian, big_endian_next;
  logic             first_pair, first_pair_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             have_held, have_held_next;
  logic             stopped, stopped_next;
  logic [CAP_W-1:0] written_count, written_count_next;

  logic        unit_en;
  logic        raw_en;
  logic [15:0] unit;
  logic [1:0]  need;
  logic        fits;
  logic        is_mark;
  logic [7:0]  b;

  assign b = in_data.in_byte;

  always_comb begin
    if (unit < 16'h0080) begin
      need = 2'd1;
    end else if (unit < 16'h0800) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
    if (raw_en) begin
      need = 2'd1;
    end
  end

  assign fits = ({1'b0, written_count} + {12'd0, need}) < {1'b0, out_capacity};

  always_comb begin
    at_start_next = at_start;
    mode_next = mode;
    big_endian_next = big_endian;
    first_pair_next = first_pair;
    held_byte_next = held_byte;
    have_held_next = have_held;
    stopped_next = stopped;
    written_count_next = written_count;
    unit_en = 1'b0;
    raw_en = 1'b0;
    unit = {8'd0, b};
    is_mark = 1'b0;
    job = '0;

    if (at_start) begin
      if (b == ENC_LATIN1) begin
        mode_next = MODE_LATIN1;
      end else if (b == ENC_UTF8) begin
        mode_next = MODE_UTF8;
      end else begin
        mode_next = MODE_UTF16;
      end
      big_endian_next = (b == ENC_UTF16_BE);
      first_pair_next = (b == ENC_UTF16_BOM);
      have_held_next = 1'b0;
      at_start_next = 1'b0;
    end else if (!stopped) begin
      unique case (mode)
        MODE_LATIN1: begin
          if (b == 8'd0) begin
            stopped_next = 1'b1;
          end else begin
            unit_en = 1'b1;
          end
        end
        MODE_UTF8: begin
          if (b == 8'd0) begin
            stopped_next = 1'b1;
          end else begin
            unit_en = 1'b1;
            raw_en = 1'b1;
          end
        end
        default: begin
          if (!have_held) begin
            held_byte_next = b;
            have_held_next = 1'b1;
          end else begin
            have_held_next = 1'b0;
            big_endian_next = big_endian;
            if (first_pair) begin
              first_pair_next = 1'b0;
              if (held_byte == 8'hFF && b == 8'hFE) begin
                big_endian_next = 1'b0;
                is_mark = 1'b1;
              end else if (held_byte == 8'hFE && b == 8'hFF) begin
                big_endian_next = 1'b1;
                is_mark = 1'b1;
              end
            end
            unit = big_endian ? {held_byte, b} : {b, held_byte};
            if (!is_mark) begin
              if (unit == 16'd0) begin
                stopped_next = 1'b1;
              end else begin
                unit_en = 1'b1;
              end
            end
          end
        end
      endcase
    end

    if (unit_en && fits) begin
      job.count = need;
      written_count_next = written_count + {{(CAP_W-2){1'b0}}, need};
      if (raw_en || need == 2'd1) begin
        job.bytes[0] = unit[7:0];
      end else if (need == 2'd2) begin
        job.bytes[0] = {3'b110, unit[10:6]};
        job.bytes[1] = {2'b10, unit[5:0]};
      end else begin
        job.bytes[0] = {4'b1110, unit[15:12]};
        job.bytes[1] = {2'b10, unit[11:6]};
        job.bytes[2] = {2'b10, unit[5:0]};
      end
    end

    if (in_data.in_last) begin
      job.term = 1'b1;
      at_start_next = 1'b1;
      mode_next = MODE_LATIN1;
      big_endian_next = 1'b0;
      first_pair_next = 1'b1;
      held_byte_next = 8'd0;
      have_held_next = 1'b0;
      stopped_next = 1'b0;
      written_count_next = '0;
    end
  end

  assign job_push = accept && (job.count != 2'd0 || job.term);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      out_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
      mode <= MODE_LATIN1;
      big_endian <= 1'b0;
      first_pair <= 1'b1;
      held_byte <= 8'd0;
      have_held <= 1'b0;
      stopped <= 1'b0;
      written_count <= '0;
    end else if (accept) begin
      at_start <= at_start_next;
      mode <= mode_next;
      big_endian <= big_endian_next;
      first_pair <= first_pair_next;
      held_byte <= held_byte_next;
      have_held <= have_held_next;
      stopped <= stopped_next;
      written_count <= written_count_next;
    end
  end

endmodule

[src/id3u8_jobq.sv]
// Small register queue of jobs between the front end and the back end.
`timescale 1ns / 1ps

module id3u8_jobq #(
  parameter int Depth = id3u8_pkg::JOBQ_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  id3u8_pkg::job_t wr_job,
  input  logic            rd,
  output logic            q_full,
  output logic            q_valid,
  output id3u8_pkg::job_t rd_job
);
  import id3u8_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_wr;
  logic            do_rd;

  assign q_full = (fill == CntFull);
  assign q_valid = (fill != '0);
  assign rd_job = slots[rd_ptr];
  assign do_wr = wr && !q_full;
  assign do_rd = rd && q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[src/id3u8_back.sv]
// Back end: walks each job and sends its bytes through the output register.
`timescale 1ns / 1ps

module id3u8_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  id3u8_pkg::job_t      cur_job,
  output logic                 q_rd,
  input  logic                 pop,
  output logic                 empty,
  output id3u8_pkg::out_word_t out_data
);
  import id3u8_pkg::*;

  logic       out_valid;
  out_word_t  out_reg;
  logic [1:0] idx;
  logic [2:0] total;
  logic       load;
  logic       done;
  out_word_t  piece;

  assign total = {1'b0, cur_job.count} + {2'd0, cur_job.term};
  assign load = q_valid && (!out_valid || pop);
  assign done = ({1'b0, idx} + 3'd1) == total;
  assign q_rd = load && done;

  always_comb begin
    if ({1'b0, idx} < {1'b0, cur_job.count}) begin
      piece.out_byte = cur_job.bytes[idx];
      piece.out_last = 1'b0;
    end else begin
      piece.out_byte = 8'd0;
      piece.out_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= piece;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= done ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;
  assign out_data = out_reg;

endmodule

[src/id3_text_to_utf8.sv]
// A word's first result is written into the job queue and then loaded into the output register.
// Throughput: one input word per cycle while the job queue has room; results leave at
// one word per cycle while pop is held, set by the single output register, so a byte
// that expands to three UTF-8 bytes leaves as three output words.
// Reset: synchronous; clears the decoder state, queue and output, capacity returns to 256.
`timescale 1ns / 1ps

module id3_text_to_utf8 #(
  parameter int JobQDepth = id3u8_pkg::JOBQ_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [id3u8_pkg::CAP_W-1:0] cfg_data,
  input  logic                        push,
  output logic                        full,
  input  id3u8_pkg::in_word_t         in_data,
  output logic                        empty,
  input  logic                        pop,
  output id3u8_pkg::out_word_t        out_data
);
  import id3u8_pkg::*;

  logic accept;
  logic job_push;
  job_t job;
  logic q_full;
  logic q_valid;
  logic q_rd;
  job_t head_job;

  assign full = q_full;
  assign accept = push && !q_full;

  id3u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_data  (in_data),
    .job_push (job_push),
    .job      (job)
  );

  id3u8_jobq #(
    .Depth (JobQDepth)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_job  (job),
    .rd      (q_rd),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_job  (head_job)
  );

  id3u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .cur_job  (head_job),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

[dv/tb_top.sv]
// Testbench for the ID3 text to UTF-8 converter: directed and random payloads checked word by word.
`timescale 1ns / 1ps

class utf8_scoreboard;
  localparam logic [7:0] MARK_HI = 8'hFF;
  localparam logic [7:0] MARK_LO = 8'hFE;

  logic [id3u8_pkg::CAP_W-1:0] capacity;
  bit                          at_start;
  id3u8_pkg::mode_t            mode;
  bit                          big_endian;
  bit                          first_pair;
  bit                          have_held;
  bit                          stopped;
  logic [7:0]                  held_byte;
  int                          written;
  id3u8_pkg::out_word_t        expected_q[$];
  int                          errors;

  function new();
    capacity = id3u8_pkg::CAP_RESET;
    errors = 0;
    clear_string();
  endfunction

  function void clear_string();
    at_start = 1;
    mode = id3u8_pkg::MODE_LATIN1;
    big_endian = 0;
    first_pair = 1;
    have_held = 0;
    stopped = 0;
    held_byte = 8'h00;
    written = 0;
  endfunction

  function bit room(int n);
    return written + n < int'(capacity);
  endfunction

  function void emit(logic [7:0] b, logic last);
    id3u8_pkg::out_word_t w;
    w.out_byte = b;
    w.out_last = last;
    expected_q.push_back(w);
  endfunction

  function void encode_unit(logic [15:0] u);
    if (u < 16'h0080) begin
      if (room(1)) begin
        emit(u[7:0], 1'b0);
        written += 1;
      end
    end else if (u < 16'h0800) begin
      if (room(2)) begin
        emit(8'hC0 | {3'b000, u[10:6]}, 1'b0);
        emit(8'h80 | {2'b00, u[5:0]}, 1'b0);
        written += 2;
      end
    end else begin
      if (room(3)) begin
        emit(8'hE0 | {4'h0, u[15:12]}, 1'b0);
        emit(8'h80 | {2'b00, u[11:6]}, 1'b0);
        emit(8'h80 | {2'b00, u[5:0]}, 1'b0);
        written += 3;
      end
    end
  endfunction

  function void note_input(id3u8_pkg::in_word_t w);
    logic [7:0]  b;
    logic [15:0] unit;
    bit          is_mark;
    b = w.in_byte;
    if (at_start) begin
      if (b == id3u8_pkg::ENC_LATIN1) mode = id3u8_pkg::MODE_LATIN1;
      else if (b == id3u8_pkg::ENC_UTF8) mode = id3u8_pkg::MODE_UTF8;
      else mode = id3u8_pkg::MODE_UTF16;
      big_endian = (b == id3u8_pkg::ENC_UTF16_BE);
      first_pair = (b == id3u8_pkg::ENC_UTF16_BOM);
      have_held = 0;
      at_start = 0;
    end else if (!stopped) begin
      case (mode)
        id3u8_pkg::MODE_LATIN1: begin
          if (b == 8'h00) stopped = 1;
          else encode_unit({8'h00, b});
        end
        id3u8_pkg::MODE_UTF8: begin
          if (b == 8'h00) begin
            stopped = 1;
          end else if (room(1)) begin
            emit(b, 1'b0);
            written += 1;
          end
        end
        default: begin
          if (!have_held) begin
            held_byte = b;
            have_held = 1;
          end else begin
            is_mark = 0;
            have_held = 0;
            if (first_pair) begin
              first_pair = 0;
              if (held_byte == MARK_HI && b == MARK_LO) begin
                big_endian = 0;
                is_mark = 1;
              end else if (held_byte == MARK_LO && b == MARK_HI) begin
                big_endian = 1;
                is_mark = 1;
              end
            end
            if (!is_mark) begin
              unit = big_endian ? {held_byte, b} : {b, held_byte};
              if (unit == 16'h0000) stopped = 1;
              else encode_unit(unit);
            end
          end
        end
      endcase
    end
    if (w.in_last) begin
      emit(8'h00, 1'b1);
      clear_string();
    end
  endfunction

  function void check_result(id3u8_pkg::out_word_t got);
    id3u8_pkg::out_word_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual byte %h last %b",
               $time, got.out_byte, got.out_last);
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte) begin
      errors++;
      $display("%0t: out_byte mismatch, expected %h, actual %h",
               $time, want.out_byte, got.out_byte);
    end
    if (got.out_last !== want.out_last) begin
      errors++;
      $display("%0t: out_last mismatch, expected %b, actual %b",
               $time, want.out_last, got.out_last);
    end
  endfunction
endclass

module tb_top;
  import id3u8_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CAP_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  in_word_t             in_data = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  out_word_t            out_data;

  utf8_scoreboard       sb = new();
  bit                   in_fast = 0;
  bit                   out_fast = 0;
  bit                   long_hold = 0;

  id3_text_to_utf8 dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  task automatic send_word(logic [7:0] b, logic last);
    in_word_t w;
    int       gap;
    w.in_byte = b;
    w.in_last = last;
    push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    sb.note_input(w);
    gap = in_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_payload(logic [7:0] pl[$]);
    for (int i = 0; i < pl.size(); i++) send_word(pl[i], i == pl.size() - 1);
  endtask

  function automatic logic [15:0] pick_unit();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 16'h0000;
    if (sel <= 6) return 16'($urandom_range(16'h0001, 16'h007F));
    if (sel <= 12) return 16'($urandom_range(16'h0080, 16'h07FF));
    if (sel <= 18) return 16'($urandom_range(16'h0800, 16'hFFFF));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic send_random_payload(output int n);
    logic [7:0]  pl[$];
    logic [7:0]  enc;
    logic [15:0] u;
    int          len;
    int          sel;
    bit          be;
    sel = $urandom_range(0, 9);
    if (sel <= 1) enc = ENC_LATIN1;
    else if (sel <= 3) enc = ENC_UTF8;
    else if (sel <= 5) enc = ENC_UTF16_BOM;
    else if (sel <= 7) enc = ENC_UTF16_BE;
    else if (sel == 8) enc = 8'($urandom_range(4, 255));
    else enc = 8'($urandom_range(0, 255));
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    pl.push_back(enc);
    if (enc == ENC_LATIN1 || enc == ENC_UTF8) begin
      for (int i = 0; i < len; i++)
        pl.push_back(($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    end else begin
      be = (enc == ENC_UTF16_BE);
      if (enc == ENC_UTF16_BOM) begin
        case ($urandom_range(0, 2))
          0: begin
            pl.push_back(8'hFF);
            pl.push_back(8'hFE);
          end
          1: begin
            pl.push_back(8'hFE);
            pl.push_back(8'hFF);
            be = 1;
          end
          default: ;
        endcase
      end
      for (int i = 0; i < len / 2; i++) begin
        if ($urandom_range(0, 9) == 0) u = 16'($urandom_range(0, 16'hFFFF));
        else u = pick_unit();
        if (be) begin
          pl.push_back(u[15:8]);
          pl.push_back(u[7:0]);
        end else begin
          pl.push_back(u[7:0]);
          pl.push_back(u[15:8]);
        end
      end
      if ($urandom_range(0, 3) == 0) pl.push_back(8'($urandom_range(0, 255)));
    end
    send_payload(pl);
    n = pl.size();
  endtask

  task automatic settle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.capacity = v;
  endtask

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = out_fast ? 0 : $urandom_range(0, 19);
      if (long_hold) begin
        long_hold = 0;
        stall = 400;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(out_data);
    end
  end

  initial begin
    logic [7:0]       pl[$];
    logic [CAP_W-1:0] cap;
    int               sent;
    int               n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pl = '{ENC_LATIN1};
    send_payload(pl);
    pl = '{ENC_LATIN1, 8'h41, 8'hFF, 8'h00, 8'h80};
    send_payload(pl);
    pl = '{ENC_UTF8, 8'hC3, 8'hA9};
    send_payload(pl);
    pl = '{ENC_UTF16_BOM, 8'hFF, 8'hFE, 8'h41, 8'h00, 8'hAC, 8'h20, 8'h7F};
    send_payload(pl);
    pl = '{ENC_UTF16_BOM, 8'hFE, 8'hFF, 8'hD8, 8'h3D};
    send_payload(pl);
    pl = '{ENC_UTF16_BE, 8'h07, 8'hFF, 8'h00, 8'h00, 8'h41};
    send_payload(pl);
    pl = '{8'hFF, 8'h00, 8'h01};
    send_payload(pl);
    push <= 1'b0;

    for (int p = 0; p < 10; p++) begin
      settle();
      case (p)
        0: cap = 13'd1;
        1: cap = 13'd4096;
        2: cap = 13'd0;
        3: cap = 13'd3;
        4: cap = 13'd8191;
        6: cap = CAP_RESET;
        7: cap = 13'd2;
        9: cap = 13'd5;
        default: cap = 13'($urandom_range(4, 40));
      endcase
      write_capacity(cap);
      in_fast = ($urandom_range(0, 3) == 0);
      out_fast = ($urandom_range(0, 3) == 0);
      if (p == 4) begin
        in_fast = 1;
        long_hold = 1;
      end
      sent = 0;
      while (sent < 55) begin
        send_random_payload(n);
        sent += n;
      end
      push <= 1'b0;
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

[sim.f]
src/id3u8_pkg.sv
src/id3u8_front.sv
src/id3u8_jobq.sv
src/id3u8_back.sv
src/id3_text_to_utf8.sv
dv/tb_top.sv
